// ----- sv/prrq_pkg.sv -----
`timescale 1ns / 1ps

package prrq_pkg;

   // Queue depth and the widths that follow from it.
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // Operation codes of an input item.
   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_SCHEDULE = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   // Status codes of a result item.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // One slot of the ready queue.
   typedef struct packed {
      logic [7:0] tid;
      logic [7:0] prio;
      logic       started;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic walk;
      logic fin;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic imm_done;
      logic imm_fin;
      logic stop;
   } stat_type;

endpackage

// ----- sv/prrq_ctrl.sv -----
`timescale 1ns / 1ps

module prrq_ctrl
   import prrq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands for the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.imm_done) begin
               state_in = S_RESP;
            end else if (stat.imm_fin) begin
               state_in = S_FIN;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.stop) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // A result strobe lasts exactly one cycle and is followed by an idle cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe held for more than one cycle");

endmodule

// ----- sv/prrq_dp.sv -----
`timescale 1ns / 1ps

module prrq_dp
   import prrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [1:0] req_op,
   input  logic [7:0] req_task_id,
   input  logic [7:0] req_priority_req,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_chosen_task,
   output logic [7:0] rsp_chosen_priority,
   output logic       rsp_first_run
);

   // Slot storage, written and read one entry a cycle.
   entry_type  mem_ff [MAX_TASKS];
   entry_type  rdat_ff;

   logic [1:0]       op_ff,      op_in;
   logic [7:0]       id_ff,      id_in;
   logic [7:0]       prio_ff,    prio_in;
   logic [1:0]       st_ff,      st_in;
   logic [CNT_W-1:0] occ_ff,     occ_in;
   logic [IDX_W-1:0] rd_ff,      rd_in;
   logic             dat_vld_ff, dat_vld_in;
   logic [IDX_W-1:0] dat_idx_ff, dat_idx_in;
   logic             found_ff,   found_in;
   entry_type        head_ff,    head_in;
   logic             first_ff,   first_in;
   logic [IDX_W-1:0] fin_idx_ff, fin_idx_in;
   entry_type        fin_dat_ff, fin_dat_in;
   logic             fin_we_ff,  fin_we_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_dat;
   logic             stop;

   logic [CNT_W-1:0] occ_m1;
   logic             occ_empty;
   logic             occ_full;
   logic             last;
   logic             match;
   entry_type        new_ent;
   entry_type        head_st;
   entry_type        rdat_st;
   logic             sched_ok;

   assign occ_m1    = occ_ff - CNT_W'(1);
   assign occ_empty = (occ_ff == '0);
   assign occ_full  = (occ_ff == CNT_W'(MAX_TASKS));
   assign last      = (CNT_W'(dat_idx_ff) == occ_m1);
   assign match     = (rdat_ff.tid == id_ff);
   assign new_ent   = '{tid: id_ff, prio: prio_ff, started: 1'b0};
   assign head_st   = '{tid: head_ff.tid, prio: head_ff.prio, started: 1'b1};
   assign rdat_st   = '{tid: rdat_ff.tid, prio: rdat_ff.prio, started: 1'b1};

   // Sequencing of one item: capture, early decision, slot walk and final write.
   always_comb begin
      op_in      = op_ff;
      id_in      = id_ff;
      prio_in    = prio_ff;
      st_in      = st_ff;
      occ_in     = occ_ff;
      rd_in      = rd_ff;
      dat_vld_in = dat_vld_ff;
      dat_idx_in = dat_idx_ff;
      found_in   = found_ff;
      head_in    = head_ff;
      first_in   = first_ff;
      fin_idx_in = fin_idx_ff;
      fin_dat_in = fin_dat_ff;
      fin_we_in  = fin_we_ff;
      wr_en      = 1'b0;
      wr_idx     = fin_idx_ff;
      wr_dat     = fin_dat_ff;
      stop       = 1'b0;

      // Capture the request. An insert walks down from the tail, the rest from the head.
      if (cmd.load) begin
         op_in      = req_op;
         id_in      = req_task_id;
         prio_in    = req_priority_req;
         st_in      = ST_OK;
         found_in   = 1'b0;
         fin_we_in  = 1'b0;
         dat_vld_in = 1'b0;
         rd_in      = (req_op == OP_INSERT) ? occ_m1[IDX_W-1:0] : '0;
      end

      // Cases settled without a walk.
      if (cmd.check) begin
         case (op_ff)
            OP_INSERT: begin
               if (occ_full) begin
                  st_in = ST_FULL;
               end else if (occ_empty) begin
                  fin_idx_in = '0;
                  fin_dat_in = new_ent;
                  fin_we_in  = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (occ_empty) begin
                  st_in = ST_NOT_FOUND;
               end
            end
            OP_SCHEDULE: begin
               if (occ_empty) begin
                  st_in = ST_EMPTY;
               end
            end
            default: begin
               st_in = ST_OK;
            end
         endcase
      end

      // One slot read is issued each cycle; the previous read is acted on.
      if (cmd.walk) begin
         rd_in      = (op_ff == OP_INSERT) ? rd_ff - IDX_W'(1) : rd_ff + IDX_W'(1);
         dat_vld_in = 1'b1;
         dat_idx_in = rd_ff;
         if (dat_vld_ff) begin
            case (op_ff)
               OP_INSERT: begin
                  if (rdat_ff.prio >= prio_ff) begin
                     stop       = 1'b1;
                     fin_idx_in = dat_idx_ff + IDX_W'(1);
                     fin_dat_in = new_ent;
                     fin_we_in  = 1'b1;
                  end else begin
                     wr_en  = 1'b1;
                     wr_idx = dat_idx_ff + IDX_W'(1);
                     wr_dat = rdat_ff;
                     if (dat_idx_ff == '0) begin
                        stop       = 1'b1;
                        fin_idx_in = '0;
                        fin_dat_in = new_ent;
                        fin_we_in  = 1'b1;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (found_ff) begin
                     wr_en  = 1'b1;
                     wr_idx = dat_idx_ff - IDX_W'(1);
                     wr_dat = rdat_ff;
                  end else if (match) begin
                     found_in = 1'b1;
                  end
                  if (last) begin
                     stop = 1'b1;
                     if (!(found_ff || match)) begin
                        st_in = ST_NOT_FOUND;
                     end
                  end
               end
               OP_SCHEDULE: begin
                  if (dat_idx_ff == '0) begin
                     head_in  = rdat_ff;
                     first_in = !rdat_ff.started;
                     if (last) begin
                        stop       = 1'b1;
                        fin_idx_in = '0;
                        fin_dat_in = rdat_st;
                        fin_we_in  = 1'b1;
                     end
                  end else if (rdat_ff.prio == head_ff.prio) begin
                     wr_en  = 1'b1;
                     wr_idx = dat_idx_ff - IDX_W'(1);
                     wr_dat = rdat_ff;
                     if (last) begin
                        stop       = 1'b1;
                        fin_idx_in = dat_idx_ff;
                        fin_dat_in = head_st;
                        fin_we_in  = 1'b1;
                     end
                  end else begin
                     stop       = 1'b1;
                     fin_idx_in = dat_idx_ff - IDX_W'(1);
                     fin_dat_in = head_st;
                     fin_we_in  = 1'b1;
                  end
               end
               default: begin
                  stop = 1'b1;
               end
            endcase
         end
      end

      // Final slot write and occupancy update.
      if (cmd.fin) begin
         wr_en = fin_we_ff;
         if (st_ff == ST_OK) begin
            if (op_ff == OP_INSERT) begin
               occ_in = occ_ff + CNT_W'(1);
            end else if (op_ff == OP_REMOVE) begin
               occ_in = occ_m1;
            end
         end
      end
   end

   // Status towards the controller.
   always_comb begin
      stat.imm_done = (op_ff == OP_NONE) || ((op_ff == OP_INSERT) && occ_full) ||
                      ((op_ff != OP_INSERT) && occ_empty);
      stat.imm_fin  = (op_ff == OP_INSERT) && occ_empty;
      stat.stop     = stop;
   end

   // Slot memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_dat;
      end
      if (cmd.walk) begin
         rdat_ff <= mem_ff[rd_ff];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         dat_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         fin_we_ff  <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         dat_vld_ff <= dat_vld_in;
         found_ff   <= found_in;
         fin_we_ff  <= fin_we_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      prio_ff    <= prio_in;
      st_ff      <= st_in;
      rd_ff      <= rd_in;
      dat_idx_ff <= dat_idx_in;
      head_ff    <= head_in;
      first_ff   <= first_in;
      fin_idx_ff <= fin_idx_in;
      fin_dat_ff <= fin_dat_in;
   end

   // Result fields; the chosen task only has meaning for a successful schedule.
   assign sched_ok            = (op_ff == OP_SCHEDULE) && (st_ff == ST_OK);
   assign rsp_status          = st_ff;
   assign rsp_chosen_task     = sched_ok ? head_ff.tid : 8'd0;
   assign rsp_chosen_priority = sched_ok ? head_ff.prio : 8'd0;
   assign rsp_first_run       = sched_ok && first_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(MAX_TASKS))
      else $error("occupancy beyond queue depth");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk && dat_vld_ff |-> CNT_W'(dat_idx_ff) < occ_ff)
      else $error("walk acted on a slot outside the queue");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.fin && (op_ff == OP_INSERT) && (st_ff == ST_OK) |=>
      occ_ff == $past(occ_ff) + CNT_W'(1))
      else $error("successful insert did not grow the queue");

endmodule

// ----- sv/priority_round_robin_ready_queue.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                         Handshake
// request   req_op, req_task_id, req_priority_req         start high, busy low
// result    rsp_status, rsp_chosen_task,                  rsp_valid, one cycle
//           rsp_chosen_priority, rsp_first_run
//
// An item is settled at once, with no walk, for an unused op, an insert into a full queue,
// or a remove or schedule on an empty one; an insert into an empty queue goes straight to
// the final write. Otherwise the walk reads one slot a cycle through the
// single read port of the slot memory, so its length grows with the occupancy.
// Reset is synchronous and clears the occupancy; slot contents need no clearing.
// The result is shown for one cycle and cannot be stalled; busy stays high until then.

module priority_round_robin_ready_queue
   import prrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [7:0] req_task_id,
   input  logic [7:0] req_priority_req,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_chosen_task,
   output logic [7:0] rsp_chosen_priority,
   output logic       rsp_first_run
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   prrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Slot storage and walk logic.
   prrq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (req_op),
      .req_task_id         (req_task_id),
      .req_priority_req    (req_priority_req),
      .rsp_status          (rsp_status),
      .rsp_chosen_task     (rsp_chosen_task),
      .rsp_chosen_priority (rsp_chosen_priority),
      .rsp_first_run       (rsp_first_run)
   );

endmodule
